// ===== src/irq_subscription_fanout_assert.svh =====
// Assertion macros for the interrupt subscription fan-out block.
`ifndef IRQ_SUBSCRIPTION_FANOUT_ASSERT_SVH
`define IRQ_SUBSCRIPTION_FANOUT_ASSERT_SVH

// Check that cons holds in the cycle after ante, outside reset.
`define ISF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after a reset cycle.
`define ISF_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/isf_pkg.sv =====
// Package: sizes, slot word layout and codes of the interrupt subscription fan-out.
`default_nettype none
package isf_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int NUM_LINES = 16;

  localparam int MASK_W  = 16;
  localparam int SLOT_AW = $clog2(NUM_SLOTS);
  localparam int LINE_AW = $clog2(NUM_LINES);
  localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
  localparam int WALK_W  = $clog2(((NUM_SLOTS > NUM_LINES) ? NUM_SLOTS : NUM_LINES) + 1);

  localparam logic [MASK_W-1:0] LINES_ALL = MASK_W'((64'd1 << NUM_LINES) - 64'd1);

  typedef enum logic [1:0] {
    MODE_REG  = 2'd0,
    MODE_SEND = 2'd1,
    MODE_WAIT = 2'd2,
    MODE_PEEK = 2'd3
  } mode_t;

  typedef struct packed {
    logic              waiting;
    logic [MASK_W-1:0] pend;
    logic [MASK_W-1:0] sub;
  } slot_word_t;

  localparam int SLOT_WORD_W = $bits(slot_word_t);

endpackage
`default_nettype wire

// ===== src/isf_if.sv =====
// Request and result channel interfaces of the interrupt subscription fan-out.
`default_nettype none
interface isf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [3:0]  slot_id;
  logic [15:0] new_mask;
  logic [3:0]  irq_line;
  logic        waiting_flag;

  modport source (output valid, mode, slot_id, new_mask, irq_line, waiting_flag,
                  input ready);
  modport sink   (input valid, mode, slot_id, new_mask, irq_line, waiting_flag,
                  output ready);
endinterface

interface isf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] line_enables;
  logic [15:0] wake_set;
  logic [15:0] slot_pending;

  modport source (output valid, line_enables, wake_set, slot_pending, input ready);
  modport sink   (input valid, line_enables, wake_set, slot_pending, output ready);
endinterface
`default_nettype wire

// ===== src/isf_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module isf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== src/irq_subscription_fanout.sv =====
// Interrupt subscription fan-out: slot and line-count tables with a walking sequencer.
//
// Requests come in on in_ch (valid/ready), one result per request leaves on
// out_ch (valid/ready). The block works on one request at a time.
// Steps from acceptance to the result register:
//   register mask (mode 0): slot read, line-count walk
//   deliver irq   (mode 1): walk of all slot words
//   set waiting / report  : one slot read-modify-write / one slot read
// The walks go through the line-count RAM and the slot RAM one entry per
// cycle, with the read of entry k overlapping the write-back of entry k-1.
// in_ch.ready is high only while the sequencer is idle, so the next request
// is taken only after the last one has left the sequencer.
// A finished result sits in an output register; the next request is
// accepted while it waits. If out_ch stalls, the following result holds in
// the sequencer until the register frees.
// Reset (rst_n low, synchronous) clears the enable bitmap and the result
// valid flag and runs a clearing walk over both RAMs, over NUM_SLOTS or
// NUM_LINES entries, whichever is larger, before the first request.
`default_nettype none
module irq_subscription_fanout (
  input  wire logic  clk,
  input  wire logic  rst_n,
  isf_in_if.sink     in_ch,
  isf_out_if.source  out_ch
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_SLOT  = 6'b000100,
    ST_LINE  = 6'b001000,
    ST_SEND  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  localparam int MW = isf_pkg::MASK_W;
  localparam int SA = isf_pkg::SLOT_AW;
  localparam int LA = isf_pkg::LINE_AW;
  localparam int CW = isf_pkg::CNT_W;
  localparam int WW = isf_pkg::WALK_W;

  state_t state_r, state_nxt;
  logic [WW-1:0] walk_r, walk_nxt;

  isf_pkg::mode_t mode_r, mode_nxt;
  logic [3:0]    slot_r, slot_nxt;
  logic [MW-1:0] mask_r, mask_nxt;
  logic [3:0]    line_r, line_nxt;
  logic          wflag_r, wflag_nxt;
  logic [MW-1:0] old_sub_r, old_sub_nxt;
  logic [MW-1:0] pend_r, pend_nxt;
  logic [MW-1:0] wake_r, wake_nxt;
  logic [MW-1:0] en_r, en_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [MW-1:0] out_en_r, out_en_nxt;
  logic [MW-1:0] out_wake_r, out_wake_nxt;
  logic [MW-1:0] out_pend_r, out_pend_nxt;

  // slot table RAM
  logic                         s_we, s_re;
  logic [SA-1:0]                s_waddr, s_raddr;
  isf_pkg::slot_word_t          s_wword, s_rword;
  logic [isf_pkg::SLOT_WORD_W-1:0] s_rdata;

  // line count RAM
  logic          l_we, l_re;
  logic [LA-1:0] l_waddr, l_raddr;
  logic [CW-1:0] l_wdata, l_rdata;

  logic [WW-1:0] prev_w;
  logic [SA-1:0] prev_slot;
  logic [LA-1:0] prev_line;
  logic          added, removed, hit;
  logic [MW-1:0] line_bit;

  isf_ram #(.WIDTH(isf_pkg::SLOT_WORD_W), .DEPTH(isf_pkg::NUM_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wword),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  isf_ram #(.WIDTH(CW), .DEPTH(isf_pkg::NUM_LINES)) u_line_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .re    (l_re),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  assign s_rword   = isf_pkg::slot_word_t'(s_rdata);
  assign prev_w    = walk_r - WW'(1);
  assign prev_slot = prev_w[SA-1:0];
  assign prev_line = prev_w[LA-1:0];
  assign line_bit  = MW'(1) << line_r;

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.line_enables = out_en_r;
  assign out_ch.wake_set     = out_wake_r;
  assign out_ch.slot_pending = out_pend_r;

  always_comb begin
    state_nxt     = state_r;
    walk_nxt      = walk_r;
    mode_nxt      = mode_r;
    slot_nxt      = slot_r;
    mask_nxt      = mask_r;
    line_nxt      = line_r;
    wflag_nxt     = wflag_r;
    old_sub_nxt   = old_sub_r;
    pend_nxt      = pend_r;
    wake_nxt      = wake_r;
    en_nxt        = en_r;
    out_valid_nxt = out_valid_r;
    out_en_nxt    = out_en_r;
    out_wake_nxt  = out_wake_r;
    out_pend_nxt  = out_pend_r;

    s_re    = 1'b0;
    s_raddr = slot_r[SA-1:0];
    s_we    = 1'b0;
    s_waddr = slot_r[SA-1:0];
    s_wword = s_rword;
    l_re    = 1'b0;
    l_raddr = walk_r[LA-1:0];
    l_we    = 1'b0;
    l_waddr = prev_line;
    l_wdata = l_rdata;
    added   = 1'b0;
    removed = 1'b0;
    hit     = 1'b0;

    // drop the result once the receiver takes it
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        // zero one entry of each table per cycle
        s_we    = (walk_r < WW'(isf_pkg::NUM_SLOTS));
        s_waddr = walk_r[SA-1:0];
        s_wword = '0;
        l_we    = (walk_r < WW'(isf_pkg::NUM_LINES));
        l_waddr = walk_r[LA-1:0];
        l_wdata = '0;
        if (walk_r == WW'(((isf_pkg::NUM_SLOTS > isf_pkg::NUM_LINES) ?
                           isf_pkg::NUM_SLOTS : isf_pkg::NUM_LINES) - 1)) begin
          state_nxt = ST_IDLE;
        end
        walk_nxt = walk_r + WW'(1);
      end

      ST_IDLE: begin
        s_re    = in_ch.valid;
        s_raddr = in_ch.slot_id[SA-1:0];
        if (in_ch.valid) begin
          mode_nxt  = isf_pkg::mode_t'(in_ch.mode);
          slot_nxt  = in_ch.slot_id;
          mask_nxt  = in_ch.new_mask & isf_pkg::LINES_ALL;
          line_nxt  = in_ch.irq_line;
          wflag_nxt = in_ch.waiting_flag;
          walk_nxt  = '0;
          wake_nxt  = '0;
          state_nxt = (isf_pkg::mode_t'(in_ch.mode) == isf_pkg::MODE_SEND) ?
                      ST_SEND : ST_SLOT;
        end
      end

      ST_SLOT: begin
        pend_nxt = s_rword.pend;
        unique case (mode_r)
          isf_pkg::MODE_REG: begin
            s_we        = 1'b1;
            s_wword     = s_rword;
            s_wword.sub = mask_r;
            old_sub_nxt = s_rword.sub;
            state_nxt   = ST_LINE;
          end
          isf_pkg::MODE_WAIT: begin
            s_we            = 1'b1;
            s_wword         = s_rword;
            s_wword.waiting = wflag_r;
            state_nxt       = ST_DONE;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end

      ST_LINE: begin
        // read line k while writing back line k-1
        l_re = (walk_r < WW'(isf_pkg::NUM_LINES));
        if (walk_r != '0) begin
          added   = mask_r[prev_line] & ~old_sub_r[prev_line];
          removed = old_sub_r[prev_line] & ~mask_r[prev_line];
          l_we    = 1'b1;
          if (added) begin
            if (l_rdata == '0) begin
              en_nxt[prev_line] = 1'b1;
            end
            l_wdata = l_rdata + CW'(1);
          end else if (removed) begin
            if (l_rdata == CW'(1)) begin
              en_nxt[prev_line] = 1'b0;
            end
            if (l_rdata != '0) begin
              l_wdata = l_rdata - CW'(1);
            end
          end
        end
        if (walk_r == WW'(isf_pkg::NUM_LINES)) begin
          state_nxt = ST_DONE;
        end
        walk_nxt = walk_r + WW'(1);
      end

      ST_SEND: begin
        // read slot k while updating slot k-1
        s_re    = (walk_r < WW'(isf_pkg::NUM_SLOTS));
        s_raddr = walk_r[SA-1:0];
        s_waddr = prev_slot;
        if (walk_r != '0) begin
          hit          = s_rword.sub[line_r];
          s_we         = hit;
          s_wword      = s_rword;
          s_wword.pend = s_rword.pend | line_bit;
          if (hit && s_rword.waiting) begin
            wake_nxt[prev_slot] = 1'b1;
          end
          if (prev_slot == slot_r[SA-1:0]) begin
            pend_nxt = hit ? (s_rword.pend | line_bit) : s_rword.pend;
          end
        end
        if (walk_r == WW'(isf_pkg::NUM_SLOTS)) begin
          state_nxt = ST_DONE;
        end
        walk_nxt = walk_r + WW'(1);
      end

      ST_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_en_nxt    = en_r;
          out_wake_nxt  = (mode_r == isf_pkg::MODE_SEND) ? wake_r : '0;
          out_pend_nxt  = pend_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      walk_r      <= '0;
      en_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_r      <= walk_nxt;
      en_r        <= en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    slot_r     <= slot_nxt;
    mask_r     <= mask_nxt;
    line_r     <= line_nxt;
    wflag_r    <= wflag_nxt;
    old_sub_r  <= old_sub_nxt;
    pend_r     <= pend_nxt;
    wake_r     <= wake_nxt;
    out_en_r   <= out_en_nxt;
    out_wake_r <= out_wake_nxt;
    out_pend_r <= out_pend_nxt;
  end

endmodule
`default_nettype wire

// ===== src/isf_checker.sv =====
// Port-level checker of the interrupt subscription fan-out and its bind.
`default_nettype none
`include "irq_subscription_fanout_assert.svh"
module isf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_line_enables,
  input wire logic [15:0] out_wake_set,
  input wire logic [15:0] out_slot_pending
);

  `ISF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "stalled result dropped")
  `ISF_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_line_enables) && $stable(out_wake_set) && $stable(out_slot_pending), "stalled result changed")
  `ISF_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "request taken while busy")
  `ISF_ASSERT_RST(a_reset_state, !out_valid && !in_ready, "reset did not clear result or start clearing walk")

endmodule

bind irq_subscription_fanout isf_checker u_isf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_line_enables (out_ch.line_enables),
  .out_wake_set     (out_ch.wake_set),
  .out_slot_pending (out_ch.slot_pending)
);
`default_nettype wire

// ===== tb/irq_subscription_fanout_tb.sv =====
// Testbench for irq_subscription_fanout: directed rows, then random requests checked by a model.
`timescale 1ns / 1ps
`default_nettype none
module irq_subscription_fanout_tb;

  localparam int RANDOM_PER_PHASE = 510;
  localparam int HOLD_CYCLES      = 400;
  localparam int DRAIN_CYCLES     = 40;
  localparam int NUM_DIRECTED     = 22;

  typedef struct {
    isf_pkg::mode_t             mode;
    logic [3:0]                 slot;
    logic [isf_pkg::MASK_W-1:0] mask;
    logic [3:0]                 line;
    logic                       wflag;
  } irq_req_t;

  typedef struct {
    logic [isf_pkg::MASK_W-1:0] enables;
    logic [isf_pkg::MASK_W-1:0] wake;
    logic [isf_pkg::MASK_W-1:0] pend;
  } fanout_report_t;

  typedef struct packed {
    isf_pkg::mode_t             mode;
    logic [3:0]                 slot;
    logic [isf_pkg::MASK_W-1:0] mask;
    logic [3:0]                 line;
    logic                       wflag;
    logic                       typed;
    logic [isf_pkg::MASK_W-1:0] enables;
    logic [isf_pkg::MASK_W-1:0] wake;
    logic [isf_pkg::MASK_W-1:0] pend;
  } directed_row_t;

  // mode, slot, mask, line, wflag, typed, enables, wake, pend
  directed_row_t directed_rows [0:NUM_DIRECTED-1] = '{
    '{isf_pkg::MODE_PEEK, 4'd0,  16'h0000, 4'd0,  1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000},
    '{isf_pkg::MODE_SEND, 4'd9,  16'hFFFF, 4'd15, 1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000},
    '{isf_pkg::MODE_REG,  4'd0,  16'hFFFF, 4'd0,  1'b0, 1'b1, 16'hFFFF, 16'h0000, 16'h0000},
    '{isf_pkg::MODE_REG,  4'd15, 16'hFFFF, 4'd15, 1'b1, 1'b1, 16'hFFFF, 16'h0000, 16'h0000},
    '{isf_pkg::MODE_WAIT, 4'd15, 16'h0000, 4'd0,  1'b1, 1'b1, 16'hFFFF, 16'h0000, 16'h0000},
    '{isf_pkg::MODE_SEND, 4'd15, 16'h0000, 4'd0,  1'b0, 1'b1, 16'hFFFF, 16'h8000, 16'h0001},
    '{isf_pkg::MODE_SEND, 4'd0,  16'hFFFF, 4'd15, 1'b0, 1'b1, 16'hFFFF, 16'h8000, 16'h8001},
    '{isf_pkg::MODE_REG,  4'd0,  16'h0000, 4'd15, 1'b1, 1'b1, 16'hFFFF, 16'h0000, 16'h8001},
    '{isf_pkg::MODE_REG,  4'd15, 16'h0000, 4'd0,  1'b0, 1'b1, 16'h0000, 16'h0000, 16'h8001},
    '{isf_pkg::MODE_SEND, 4'd15, 16'hFFFF, 4'd0,  1'b1, 1'b1, 16'h0000, 16'h0000, 16'h8001},
    '{isf_pkg::MODE_REG,  4'd3,  16'h00A5, 4'd7,  1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{isf_pkg::MODE_REG,  4'd7,  16'h5A00, 4'd2,  1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{isf_pkg::MODE_WAIT, 4'd3,  16'h1234, 4'd9,  1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{isf_pkg::MODE_WAIT, 4'd7,  16'hFFFF, 4'd0,  1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{isf_pkg::MODE_SEND, 4'd3,  16'h0000, 4'd5,  1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{isf_pkg::MODE_SEND, 4'd7,  16'h0000, 4'd9,  1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{isf_pkg::MODE_REG,  4'd3,  16'h0F0F, 4'd0,  1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{isf_pkg::MODE_WAIT, 4'd3,  16'h0000, 4'd15, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{isf_pkg::MODE_SEND, 4'd3,  16'hFFFF, 4'd0,  1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{isf_pkg::MODE_PEEK, 4'd7,  16'hFFFF, 4'd15, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{isf_pkg::MODE_REG,  4'd7,  16'h5A00, 4'd11, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{isf_pkg::MODE_REG,  4'd3,  16'h0000, 4'd8,  1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000}
  };

  logic clk;
  logic rst_n;

  isf_in_if  in_if ();
  isf_out_if out_if ();

  irq_subscription_fanout dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Model copy of the subscription tables.
  logic [isf_pkg::MASK_W-1:0] model_sub   [isf_pkg::NUM_SLOTS];
  logic [isf_pkg::MASK_W-1:0] model_pend  [isf_pkg::NUM_SLOTS];
  logic                       model_wait  [isf_pkg::NUM_SLOTS];
  logic [isf_pkg::CNT_W-1:0]  model_count [isf_pkg::NUM_LINES];
  logic [isf_pkg::MASK_W-1:0] model_enables;

  fanout_report_t expected_reports [$];

  int src_idle_pct;
  int sink_idle_pct;
  int hold_requests;
  int hold_served;
  int hold_left;
  int fail_count;
  int reports_checked;
  int wake_reports;
  int mode_counts [4];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("irq_subscription_fanout verification failed");
    $finish;
  end

  function automatic fanout_report_t fanout_step(input irq_req_t req);
    fanout_report_t rep;
    logic [isf_pkg::MASK_W-1:0] old_mask;
    logic [isf_pkg::MASK_W-1:0] new_mask;
    logic [isf_pkg::MASK_W-1:0] added;
    logic [isf_pkg::MASK_W-1:0] removed;
    rep.wake = '0;
    case (req.mode)
      isf_pkg::MODE_REG: begin
        old_mask = model_sub[req.slot];
        new_mask = req.mask & isf_pkg::LINES_ALL;
        added    = new_mask & ~old_mask;
        removed  = old_mask & ~new_mask;
        model_sub[req.slot] = new_mask;
        for (int i = 0; i < isf_pkg::NUM_LINES; i++) begin
          if (added[i]) begin
            if (model_count[i] == 0) model_enables[i] = 1'b1;
            model_count[i] = model_count[i] + 1'b1;
          end
        end
        for (int i = 0; i < isf_pkg::NUM_LINES; i++) begin
          if (removed[i]) begin
            if (model_count[i] == 1) model_enables[i] = 1'b0;
            if (model_count[i] != 0) model_count[i] = model_count[i] - 1'b1;
          end
        end
      end
      isf_pkg::MODE_SEND: begin
        for (int i = 0; i < isf_pkg::NUM_SLOTS; i++) begin
          if (model_sub[i][req.line]) begin
            model_pend[i][req.line] = 1'b1;
            if (model_wait[i]) rep.wake[i] = 1'b1;
          end
        end
      end
      isf_pkg::MODE_WAIT: model_wait[req.slot] = req.wflag;
      default: ;
    endcase
    rep.enables = model_enables;
    rep.pend    = model_pend[req.slot];
    return rep;
  endfunction

  function automatic irq_req_t random_request();
    irq_req_t req;
    int pick;
    pick       = $urandom_range(99);
    req.mode   = (pick < 30) ? isf_pkg::MODE_REG : (pick < 65) ? isf_pkg::MODE_SEND :
                 (pick < 85) ? isf_pkg::MODE_WAIT : isf_pkg::MODE_PEEK;
    req.slot   = 4'($urandom_range(15));
    req.line   = 4'($urandom_range(15));
    req.wflag  = ($urandom_range(99) < 60);
    // Half of the masks are sparse so that line counts move up and down.
    case ($urandom_range(7))
      0:       req.mask = '0;
      1:       req.mask = '1;
      2, 3:    req.mask = isf_pkg::MASK_W'(1) << $urandom_range(isf_pkg::MASK_W - 1);
      4:       req.mask = isf_pkg::MASK_W'($urandom) & isf_pkg::MASK_W'($urandom);
      default: req.mask = isf_pkg::MASK_W'($urandom);
    endcase
    return req;
  endfunction

  task automatic offer_request(input irq_req_t req, input bit typed,
                               input fanout_report_t typed_rep);
    fanout_report_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.mode         <= req.mode;
    in_if.slot_id      <= req.slot;
    in_if.new_mask     <= req.mask;
    in_if.irq_line     <= req.line;
    in_if.waiting_flag <= req.wflag;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predicted = fanout_step(req);
    mode_counts[req.mode] = mode_counts[req.mode] + 1;
    expected_reports.push_back(typed ? typed_rep : predicted);
  endtask

  // Result side: random back-pressure plus a long hold when requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin : report_check
    fanout_report_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result: line_enables %h wake_set %h slot_pending %h",
               out_if.line_enables, out_if.wake_set, out_if.slot_pending);
        fail_count = fail_count + 1;
      end else begin
        want = expected_reports.pop_front();
        reports_checked = reports_checked + 1;
        if (out_if.wake_set != 0) wake_reports = wake_reports + 1;
        if (out_if.line_enables !== want.enables) begin
          $error("line_enables expected %h actual %h", want.enables, out_if.line_enables);
          fail_count = fail_count + 1;
        end
        if (out_if.wake_set !== want.wake) begin
          $error("wake_set expected %h actual %h", want.wake, out_if.wake_set);
          fail_count = fail_count + 1;
        end
        if (out_if.slot_pending !== want.pend) begin
          $error("slot_pending expected %h actual %h", want.pend, out_if.slot_pending);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  initial begin : stimulus
    irq_req_t req;
    fanout_report_t typed_rep;
    directed_row_t row;
    src_idle_pct    = 14;
    sink_idle_pct   = 84;
    hold_requests   = 0;
    hold_served     = 0;
    hold_left       = 0;
    fail_count      = 0;
    reports_checked = 0;
    wake_reports    = 0;
    foreach (mode_counts[i]) mode_counts[i] = 0;
    for (int i = 0; i < isf_pkg::NUM_SLOTS; i++) begin
      model_sub[i]  = '0;
      model_pend[i] = '0;
      model_wait[i] = 1'b0;
    end
    for (int i = 0; i < isf_pkg::NUM_LINES; i++) model_count[i] = '0;
    model_enables = '0;

    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.mode         = isf_pkg::MODE_PEEK;
    in_if.slot_id      = '0;
    in_if.new_mask     = '0;
    in_if.irq_line     = '0;
    in_if.waiting_flag = 1'b0;
    out_if.ready       = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      req = '{row.mode, row.slot, row.mask, row.line, row.wflag};
      typed_rep = '{row.enables, row.wake, row.pend};
      offer_request(req, row.typed, typed_rep);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 14;
          sink_idle_pct = 84;
        end
        1: begin
          src_idle_pct  = 84;
          sink_idle_pct = 14;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
          // Stall the result side while requests keep coming.
          hold_requests = hold_requests + 1;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        req = random_request();
        offer_request(req, 1'b0, typed_rep);
      end
    end
    in_if.valid <= 1'b0;

    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d reports: %0d mask updates, %0d deliveries (%0d woke slots),",
             reports_checked, mode_counts[isf_pkg::MODE_REG],
             mode_counts[isf_pkg::MODE_SEND], wake_reports);
    $display("%0d waiting-flag writes and %0d peeks, across three idle mixes and a long hold",
             mode_counts[isf_pkg::MODE_WAIT], mode_counts[isf_pkg::MODE_PEEK]);
    if (fail_count == 0 && expected_reports.size() == 0) begin
      $display("irq_subscription_fanout verification clean");
    end else begin
      $display("irq_subscription_fanout verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
